### rtl/matrix_chain_order_cost_defines.svh
// assertion macros shared by the matrix chain cost rtl
`ifndef MATRIX_CHAIN_ORDER_COST_DEFINES_SVH
`define MATRIX_CHAIN_ORDER_COST_DEFINES_SVH
`ifndef SYNTHESIS
`define MCOC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MCOC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MCOC_ASSERT(lbl, prop, msg)
`define MCOC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/mcoc_pkg.sv
// types and constants shared by the matrix chain cost controller and datapath
`timescale 1ns / 1ps
package mcoc_pkg;

	localparam int COST_W = 63;
	localparam int SPLIT_W = 5;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_MATRIX = 2'd1,
		STATUS_TRUNCATED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_CELL_PI,
		ST_CELL_PJ,
		ST_CELL_CAP,
		ST_K_READ,
		ST_K_MUL1,
		ST_K_MUL2,
		ST_K_TRI,
		ST_K_CMP,
		ST_CELL_WR,
		ST_FINISH
	} state_t;

	// dimension store read address select
	typedef enum logic [1:0] {
		DSEL_I,
		DSEL_J1,
		DSEL_K1
	} dim_sel_t;

	typedef struct packed {
		logic     load;
		logic     start;
		logic     cell_init;
		dim_sel_t dim_sel;
		logic     cap_pi;
		logic     cap_pj;
		logic     cmp;
		logic     cell_wr;
		logic     cell_next;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic short_chain;
		logic k_last;
		logic table_done;
		logic out_free;
	} sts_t;

endpackage

### rtl/mcoc_ctrl.sv
// sequencing state machine for the matrix chain cost fill
`timescale 1ns / 1ps
`include "matrix_chain_order_cost_defines.svh"
module mcoc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dim_valid,
	input  logic           last_dimension,
	output logic           dim_stall,
	input  mcoc_pkg::sts_t sts,
	output mcoc_pkg::cmd_t cmd
);

	mcoc_pkg::state_t state_q;
	mcoc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcoc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.dim_sel = mcoc_pkg::DSEL_I;
		dim_stall = 1'b1;
		case (state_q)
			mcoc_pkg::ST_LOAD: begin
				dim_stall = 1'b0;
				if (dim_valid) begin
					cmd.load = 1'b1;
					if (last_dimension) begin
						state_d = mcoc_pkg::ST_START;
					end
				end
			end
			mcoc_pkg::ST_START: begin
				if (sts.short_chain) begin
					state_d = mcoc_pkg::ST_FINISH;
				end else begin
					cmd.start = 1'b1;
					state_d = mcoc_pkg::ST_CELL_PI;
				end
			end
			mcoc_pkg::ST_CELL_PI: begin
				cmd.dim_sel = mcoc_pkg::DSEL_I;
				cmd.cell_init = 1'b1;
				state_d = mcoc_pkg::ST_CELL_PJ;
			end
			mcoc_pkg::ST_CELL_PJ: begin
				cmd.dim_sel = mcoc_pkg::DSEL_J1;
				cmd.cap_pi = 1'b1;
				state_d = mcoc_pkg::ST_CELL_CAP;
			end
			mcoc_pkg::ST_CELL_CAP: begin
				cmd.cap_pj = 1'b1;
				state_d = mcoc_pkg::ST_K_READ;
			end
			mcoc_pkg::ST_K_READ: begin
				cmd.dim_sel = mcoc_pkg::DSEL_K1;
				state_d = mcoc_pkg::ST_K_MUL1;
			end
			mcoc_pkg::ST_K_MUL1: begin
				state_d = mcoc_pkg::ST_K_MUL2;
			end
			mcoc_pkg::ST_K_MUL2: begin
				state_d = mcoc_pkg::ST_K_TRI;
			end
			mcoc_pkg::ST_K_TRI: begin
				state_d = mcoc_pkg::ST_K_CMP;
			end
			mcoc_pkg::ST_K_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.k_last) begin
					state_d = mcoc_pkg::ST_CELL_WR;
				end else begin
					state_d = mcoc_pkg::ST_K_READ;
				end
			end
			mcoc_pkg::ST_CELL_WR: begin
				cmd.cell_wr = 1'b1;
				if (sts.table_done) begin
					state_d = mcoc_pkg::ST_FINISH;
				end else begin
					cmd.cell_next = 1'b1;
					state_d = mcoc_pkg::ST_CELL_PI;
				end
			end
			mcoc_pkg::ST_FINISH: begin
				// hold until the result register can take a new result
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = mcoc_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = mcoc_pkg::ST_LOAD;
			end
		endcase
	end

	`MCOC_ASSERT(a_finish_needs_free, cmd.finish |-> sts.out_free, "result overwritten")
	`MCOC_ASSERT_NEXT(a_last_starts_fill, (state_q == mcoc_pkg::ST_LOAD) && dim_valid && last_dimension, state_q == mcoc_pkg::ST_START, "last transfer did not start fill")

endmodule

### rtl/mcoc_dp.sv
// dimension store, cost table and saturating cost arithmetic
`timescale 1ns / 1ps
`include "matrix_chain_order_cost_defines.svh"
module mcoc_dp #(
	parameter int MAX_MATRICES = 32,
	parameter int DIM_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcoc_pkg::cmd_t                cmd,
	output mcoc_pkg::sts_t                sts,
	input  logic [DIM_BITS-1:0]           dimension,
	input  logic                          res_stall,
	output logic                          res_valid,
	output logic [mcoc_pkg::COST_W-1:0]   min_cost,
	output logic [mcoc_pkg::SPLIT_W-1:0]  top_split,
	output logic [1:0]                    status
);

	localparam int DEPTH = MAX_MATRICES + 1;
	localparam int IW = $clog2(MAX_MATRICES);
	localparam int DAW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int CAW = 2 * IW;
	localparam int CDEPTH = MAX_MATRICES << IW;
	localparam int PROD_W = 2 * DIM_BITS;
	localparam int TRI_W = (3 * DIM_BITS > mcoc_pkg::COST_W + 1) ? 3 * DIM_BITS
		: mcoc_pkg::COST_W + 1;
	localparam int SUM_W = mcoc_pkg::COST_W + 2;
	localparam int SPLIT_XW = IW + mcoc_pkg::SPLIT_W;

	// control state
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] nlast_q;
	logic          have_q;
	logic          res_valid_q;

	// memories
	logic [DIM_BITS-1:0]        dim_mem [DEPTH];
	logic [DIM_BITS-1:0]        dim_rd_q;
	logic [mcoc_pkg::COST_W-1:0] cost_mem [CDEPTH];
	logic [mcoc_pkg::COST_W-1:0] cost_a_q;
	logic [mcoc_pkg::COST_W-1:0] cost_b_q;
	logic                        diag_a_q;
	logic                        diag_b_q;

	// arithmetic
	logic [DIM_BITS-1:0]         p_i_q;
	logic [DIM_BITS-1:0]         p_j1_q;
	logic [mcoc_pkg::COST_W:0]   sum_s1;
	logic [mcoc_pkg::COST_W:0]   sum_s2;
	logic [mcoc_pkg::COST_W:0]   sum_s3;
	logic [PROD_W-1:0]           ab_s1;
	logic [PROD_W-1:0]           pp_hi_s2;
	logic [PROD_W-1:0]           pp_lo_s2;
	logic [mcoc_pkg::COST_W-1:0] tri_s3;
	logic [mcoc_pkg::COST_W-1:0] best_q;
	logic [IW-1:0]               best_k_q;

	// result register
	logic [mcoc_pkg::COST_W-1:0]  min_cost_q;
	logic [mcoc_pkg::SPLIT_W-1:0] top_split_q;
	mcoc_pkg::status_t            status_q;

	logic                        store_en;
	logic [IW-1:0]               k1;
	logic [DAW-1:0]              dim_addr;
	logic [CAW-1:0]              addr_w;
	logic [CAW-1:0]              addr_a;
	logic [CAW-1:0]              addr_b;
	logic [mcoc_pkg::COST_W-1:0] a_eff;
	logic [mcoc_pkg::COST_W-1:0] b_eff;
	logic [TRI_W-1:0]            tri_full;
	logic [mcoc_pkg::COST_W-1:0] tri_sat;
	logic [SUM_W-1:0]            cand_full;
	logic [mcoc_pkg::COST_W-1:0] cand;
	logic [SPLIT_XW-1:0]         split_ext;

	assign store_en = cmd.load && (count_q < CW'(DEPTH));
	assign k1 = k_q + IW'(1);
	assign addr_w = {i_q, j_q};
	assign addr_a = {i_q, k_q};
	assign addr_b = {k1, j_q};

	always_comb begin
		case (cmd.dim_sel)
			mcoc_pkg::DSEL_I:  dim_addr = DAW'(i_q);
			mcoc_pkg::DSEL_J1: dim_addr = DAW'(j_q) + DAW'(1);
			mcoc_pkg::DSEL_K1: dim_addr = DAW'(k_q) + DAW'(1);
			default:           dim_addr = DAW'(i_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			dim_mem[count_q[DAW-1:0]] <= dimension;
		end
		dim_rd_q <= dim_mem[dim_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cell_wr) begin
			cost_mem[addr_w] <= best_q;
		end
		cost_a_q <= cost_mem[addr_a];
		cost_b_q <= cost_mem[addr_b];
	end

	// diagonal entries are never written and read as zero cost
	assign a_eff = diag_a_q ? '0 : cost_a_q;
	assign b_eff = diag_b_q ? '0 : cost_b_q;

	assign tri_full = (TRI_W'(pp_hi_s2) << DIM_BITS) + TRI_W'(pp_lo_s2);
	assign tri_sat = (tri_full > TRI_W'(mcoc_pkg::COST_MAX)) ? mcoc_pkg::COST_MAX
		: tri_full[mcoc_pkg::COST_W-1:0];

	assign cand_full = SUM_W'(sum_s3) + SUM_W'(tri_s3);
	assign cand = (cand_full >= SUM_W'(mcoc_pkg::COST_MAX)) ? mcoc_pkg::COST_MAX
		: cand_full[mcoc_pkg::COST_W-1:0];

	assign split_ext = SPLIT_XW'(best_k_q);

	// product p[i]*p[k+1]*p[j+1] split into two half-width partial products
	always_ff @(posedge clk) begin
		diag_a_q <= (k_q == i_q);
		diag_b_q <= (k1 == j_q);
		sum_s1 <= {1'b0, a_eff} + {1'b0, b_eff};
		sum_s2 <= sum_s1;
		sum_s3 <= sum_s2;
		ab_s1 <= PROD_W'(p_i_q) * PROD_W'(dim_rd_q);
		pp_hi_s2 <= PROD_W'(ab_s1[PROD_W-1:DIM_BITS]) * PROD_W'(p_j1_q);
		pp_lo_s2 <= PROD_W'(ab_s1[DIM_BITS-1:0]) * PROD_W'(p_j1_q);
		tri_s3 <= tri_sat;
		if (cmd.cap_pi) begin
			p_i_q <= dim_rd_q;
		end
		if (cmd.cap_pj) begin
			p_j1_q <= dim_rd_q;
		end
		// strict compare keeps the smallest split among equal costs
		if (cmd.cmp && (!have_q || (cand < best_q))) begin
			best_q <= cand;
			best_k_q <= k_q;
		end
		if (cmd.finish) begin
			if (count_q > CW'(2)) begin
				min_cost_q <= best_q;
				top_split_q <= split_ext[mcoc_pkg::SPLIT_W-1:0];
			end else begin
				min_cost_q <= '0;
				top_split_q <= '0;
			end
			if (count_q < CW'(2)) begin
				status_q <= mcoc_pkg::STATUS_NO_MATRIX;
			end else if (ovf_q) begin
				status_q <= mcoc_pkg::STATUS_TRUNCATED;
			end else begin
				status_q <= mcoc_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			nlast_q <= '0;
			have_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (store_en) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				nlast_q <= IW'(count_q - CW'(2));
				i_q <= '0;
				j_q <= IW'(1);
			end
			if (cmd.cell_init) begin
				k_q <= i_q;
				have_q <= 1'b0;
			end
			if (cmd.cmp) begin
				k_q <= k1;
				have_q <= 1'b1;
			end
			if (cmd.cell_next) begin
				// end of a diagonal moves to the next chain length
				if (j_q == nlast_q) begin
					i_q <= '0;
					j_q <= j_q - i_q + IW'(1);
				end else begin
					i_q <= i_q + IW'(1);
					j_q <= j_q + IW'(1);
				end
			end
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.short_chain = (count_q <= CW'(2));
	assign sts.k_last = (k1 == j_q);
	assign sts.table_done = (i_q == '0) && (j_q == nlast_q);
	assign sts.out_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign min_cost = min_cost_q;
	assign top_split = top_split_q;
	assign status = status_q;

	`MCOC_ASSERT(a_cmp_inside_cell, cmd.cmp |-> (k_q >= i_q) && (k_q < j_q), "split outside cell")
	`MCOC_ASSERT(a_write_after_cmp, cmd.cell_wr |-> have_q, "cell written with no split tried")
	`MCOC_ASSERT_NEXT(a_finish_clears, cmd.finish, (count_q == '0) && !ovf_q && res_valid_q, "chain state not cleared")

endmodule

### rtl/matrix_chain_order_cost.sv
// matrix chain multiplication least cost, top level
//
// channel     direction  fields                                handshake
// dimension   in         dimension, last_dimension              dim_valid / dim_stall
// result      out        min_cost, top_split, status            res_valid / res_stall
//
// one dimension per cycle while loading; after the last transfer dim_stall stays high
// for the fill and until the result register can take the new result; splits go
// one at a time through the single shared multiply and compare step (read, multiply,
// triangle and compare states), and each cell first fetches p[i] and p[j+1]
// from the one-port dimension store and ends by writing the cell
// reset clears control state only; the stores need no clearing pass
// a finished result sits in the output register until taken, and the next chain
// loads meanwhile; a fill completing while the result is still stalled waits for it
`timescale 1ns / 1ps
module matrix_chain_order_cost #(
	parameter int MAX_MATRICES = 32,
	parameter int DIM_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         dim_valid,
	output logic                         dim_stall,
	input  logic [DIM_BITS-1:0]          dimension,
	input  logic                         last_dimension,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [mcoc_pkg::COST_W-1:0]  min_cost,
	output logic [mcoc_pkg::SPLIT_W-1:0] top_split,
	output logic [1:0]                   status
);

	mcoc_pkg::cmd_t cmd;
	mcoc_pkg::sts_t sts;

	mcoc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.dim_valid      (dim_valid),
		.last_dimension (last_dimension),
		.dim_stall      (dim_stall),
		.sts            (sts),
		.cmd            (cmd)
	);

	mcoc_dp #(
		.MAX_MATRICES (MAX_MATRICES),
		.DIM_BITS     (DIM_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.dimension (dimension),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.min_cost  (min_cost),
		.top_split (top_split),
		.status    (status)
	);

endmodule
